>>> hdl/hbkd_pkg.sv
// Shared types and constants for the boot keyboard report differ.
package hbkd_pkg;

   localparam int KEY_SLOTS      = 6;
   localparam int MAX_SLOTS      = 6;
   localparam int CODE_W         = 8;
   localparam int REPORT_BYTES_W = 7;
   localparam int EVENT_SLOTS    = 2 * KEY_SLOTS;
   localparam int SLOT_IDX_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int EVENT_IDX_W    = SLOT_IDX_W + 1;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [REPORT_BYTES_W-1:0] MIN_REPORT_BYTES = REPORT_BYTES_W'(8);

   typedef logic [CODE_W-1:0] code_type;

   // One classified report: mask bit 2*i is a release of old_codes[i],
   // bit 2*i+1 a press of new_codes[i].
   typedef struct packed {
      logic [EVENT_SLOTS-1:0]            mask;
      logic [KEY_SLOTS-1:0][CODE_W-1:0]  old_codes;
      logic [KEY_SLOTS-1:0][CODE_W-1:0]  new_codes;
   } queue_entry_type;

endpackage

>>> hdl/hbkd_if.sv
// Channel interfaces: report input and key event output.
interface hbkd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] slot_code_0;
   logic [7:0] slot_code_1;
   logic [7:0] slot_code_2;
   logic [7:0] slot_code_3;
   logic [7:0] slot_code_4;
   logic [7:0] slot_code_5;
   logic [6:0] report_bytes;

   modport source (
      output valid, slot_code_0, slot_code_1, slot_code_2, slot_code_3,
             slot_code_4, slot_code_5, report_bytes,
      input  ready
   );
   modport sink (
      input  valid, slot_code_0, slot_code_1, slot_code_2, slot_code_3,
             slot_code_4, slot_code_5, report_bytes,
      output ready
   );
endinterface

interface hbkd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] event_code;
   logic       is_press;
   logic       last_event;

   modport source (output valid, event_code, is_press, last_event, input ready);
   modport sink (input valid, event_code, is_press, last_event, output ready);
endinterface

>>> hdl/hbkd_front.sv
// Front end: accepts reports, classifies press/release per slot, keeps previous codes.
module hbkd_front import hbkd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   hbkd_req_if.sink        req_bus,
   input  logic            queue_full,
   output logic            push,
   output queue_entry_type push_entry
);

   logic [MAX_SLOTS-1:0][CODE_W-1:0] fresh;
   logic [KEY_SLOTS-1:0][CODE_W-1:0] prev_ff, prev_in;
   logic [EVENT_SLOTS-1:0]           mask;
   logic                             accept;
   logic                             long_report;
   logic                             in_fresh;
   logic                             in_prev;

   assign fresh[0] = req_bus.slot_code_0;
   assign fresh[1] = req_bus.slot_code_1;
   assign fresh[2] = req_bus.slot_code_2;
   assign fresh[3] = req_bus.slot_code_3;
   assign fresh[4] = req_bus.slot_code_4;
   assign fresh[5] = req_bus.slot_code_5;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && !queue_full;
   assign long_report   = req_bus.report_bytes >= MIN_REPORT_BYTES;

   always_comb begin
      mask = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         in_fresh = 1'b0;
         in_prev  = 1'b0;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (fresh[j] == prev_ff[i]) in_fresh = 1'b1;
            if (prev_ff[j] == fresh[i]) in_prev = 1'b1;
         end
         mask[2*i]   = (prev_ff[i] != '0) && !in_fresh;
         mask[2*i+1] = (fresh[i] != '0) && !in_prev;
      end
   end

   always_comb begin
      push_entry.mask = mask;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         push_entry.old_codes[i] = prev_ff[i];
         push_entry.new_codes[i] = fresh[i];
      end
   end

   // Reports without any change update state but enqueue nothing.
   assign push = accept && long_report && (mask != '0);

   always_comb begin
      prev_in = prev_ff;
      if (accept && long_report) begin
         for (int i = 0; i < KEY_SLOTS; i++) prev_in[i] = fresh[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

>>> hdl/hbkd_fifo.sv
// Short queue of classified reports between front and back ends.
module hbkd_fifo import hbkd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   input  logic            pop,
   output queue_entry_type head,
   output logic            full,
   output logic            empty
);

   queue_entry_type          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign full  = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("pop from empty queue");
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      QUEUE_PTR_W'(wr_ptr_ff - rd_ptr_ff) == QUEUE_PTR_W'(count_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

>>> hdl/hbkd_back.sv
// Back end: serializes the events of the queue head into the output register.
module hbkd_back import hbkd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            queue_empty,
   input  queue_entry_type head,
   output logic            pop,
   hbkd_rsp_if.source      rsp_bus
);

   logic [EVENT_SLOTS-1:0] done_ff, done_in;
   logic [EVENT_SLOTS-1:0] remaining;
   logic [EVENT_SLOTS-1:0] pick;
   logic [EVENT_IDX_W-1:0] idx;
   logic [SLOT_IDX_W-1:0]  slot;
   logic                   out_free;
   logic                   fire;
   logic                   last;
   logic                   rsp_valid_ff, rsp_valid_in;
   code_type               rsp_code_ff;
   logic                   rsp_press_ff;
   logic                   rsp_last_ff;

   assign remaining = head.mask & ~done_ff;
   assign pick      = remaining & (~remaining + 1'b1);
   assign last      = (remaining & ~pick) == '0;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign fire      = !queue_empty && out_free;
   assign pop       = fire && last;

   always_comb begin
      idx = '0;
      for (int i = 0; i < EVENT_SLOTS; i++) begin
         if (pick[i]) idx = idx | EVENT_IDX_W'(i);
      end
   end

   assign slot = idx[EVENT_IDX_W-1:1];

   always_comb begin
      done_in = done_ff;
      if (fire) done_in = last ? '0 : (done_ff | pick);
      rsp_valid_in = rsp_valid_ff;
      if (fire) rsp_valid_in = 1'b1;
      else if (rsp_bus.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_code_ff  <= idx[0] ? head.new_codes[slot] : head.old_codes[slot];
         rsp_press_ff <= idx[0];
         rsp_last_ff  <= last;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.event_code = rsp_code_ff;
   assign rsp_bus.is_press   = rsp_press_ff;
   assign rsp_bus.last_event = rsp_last_ff;

endmodule

>>> hdl/hid_boot_report_key_differ_top.sv
// Top level of the HID boot keyboard report differ.
// Usage:
//   req_bus carries one boot keyboard report per transfer: six key-code slots
//   and the report length. Reports shorter than 8 bytes are dropped with no
//   effect. Each other report is compared against the stored codes of the
//   previous one, and per slot a release (old code gone) then a press (new
//   code not seen before) is produced.
//   rsp_bus carries one key event per transfer; last_event marks the final
//   event of a report. A report with no change produces no transfer.
// Throughput: one event per cycle while the output register is free, set by
//   the single back-end serializer; a report has 0 to 12 events. The front end
//   takes one report per cycle while the four-entry report queue has room.
// Reset: stored codes clear to zero, the queue empties, rsp_bus.valid drops.
// Stall: when rsp_bus.ready is low the output register holds its event, the
//   back end stops, the queue fills, and then req_bus.ready drops.
module hid_boot_report_key_differ_top import hbkd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hbkd_req_if.sink   req_bus,
   hbkd_rsp_if.source rsp_bus
);

   logic            push;
   logic            pop;
   logic            queue_full;
   logic            queue_empty;
   queue_entry_type push_entry;
   queue_entry_type head;

   // Classify each report and update the stored codes at the transfer.
   hbkd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Hold classified reports so front and back stall independently.
   hbkd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // Advance through the head report one event per cycle while the output register is free.
   hbkd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

endmodule
